// ===== hdl/ers_pkg.sv =====
package ers_pkg;

   // Field widths fixed by the interface
   localparam int KIND_W        = 1;
   localparam int SLOT_IDX_W    = 3;
   localparam int CHUNK_W       = 16;
   localparam int EXT_LEN_W     = 17;
   localparam int OFFSET_W      = 25;
   localparam int LENGTH_W      = 15;
   localparam int BUF_W         = 16;
   localparam int FCC_W         = 17;
   localparam int SEG_START_W   = 9;
   localparam int SEG_BYTES_W   = 10;
   localparam int STATUS_W      = 3;

   // Chunk geometry and read limit
   localparam int CHUNK_LOG2     = 9;
   localparam int CHUNK_BYTES    = 1 << CHUNK_LOG2;
   localparam int BYTES_W        = CHUNK_LOG2 + 1;
   localparam int MAX_READ_BYTES = 16384;

   localparam int DEFAULT_EXTENT_SLOTS = 8;

   // Logical chunk position, with room for the pieces past the first one
   localparam int POS_W     = OFFSET_W - CHUNK_LOG2 + 1;
   localparam int POS_CMP_W = (POS_W > FCC_W) ? POS_W : FCC_W;
   // Bounds check: offset + length against file_chunk_count * CHUNK_BYTES
   localparam int CHK_W     = ((OFFSET_W + 1) > (FCC_W + CHUNK_LOG2)) ?
                              (OFFSET_W + 1) : (FCC_W + CHUNK_LOG2);

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_OOB         = 3'd1,
      STAT_ZERO_LEN    = 3'd2,
      STAT_BUF_SMALL   = 3'd3,
      STAT_NOT_IN_FILE = 3'd4,
      STAT_EXTENTS_END = 3'd5,
      STAT_TOO_LONG    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      EMIT_ACK,
      EMIT_CHECK,
      EMIT_WALK
   } emit_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACK,
      ST_CHECK,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic          take_req;
      logic          start_walk;
      logic          step_slot;
      logic          next_piece;
      logic          emit;
      emit_kind_type emit_kind;
   } ers_cmd_type;

   typedef struct packed {
      logic req_is_read;
      logic check_fail;
      logic walk_done;
      logic walk_err;
      logic piece_last;
      logic out_free;
   } ers_status_type;

endpackage

// ===== hdl/ers_ctrl.sv =====
module ers_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ers_pkg::ers_status_type stat,
   output ers_pkg::ers_cmd_type    cmd
);
   import ers_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_is_read ? ST_CHECK : ST_ACK;
            end
         end
         ST_ACK: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (!stat.check_fail) begin
               state_in = ST_WALK;
            end else if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (stat.walk_done && stat.out_free && (stat.walk_err || stat.piece_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.emit_kind  = EMIT_ACK;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         ST_ACK: begin
            cmd.emit = stat.out_free;
         end
         ST_CHECK: begin
            cmd.emit_kind  = EMIT_CHECK;
            cmd.start_walk = !stat.check_fail;
            cmd.emit       = stat.check_fail && stat.out_free;
         end
         ST_WALK: begin
            cmd.emit_kind = EMIT_WALK;
            if (stat.walk_done) begin
               // hold the resolved piece until the output register frees up
               cmd.emit       = stat.out_free;
               cmd.next_piece = stat.out_free && !stat.walk_err && !stat.piece_last;
            end else begin
               cmd.step_slot = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/ers_datapath.sv =====
module ers_datapath #(
   parameter int EXTENT_SLOTS = ers_pkg::DEFAULT_EXTENT_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ers_pkg::ers_cmd_type              cmd,
   output ers_pkg::ers_status_type           stat,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ers_pkg::FCC_W-1:0]         csr_wdata,
   input  logic [ers_pkg::KIND_W-1:0]        req_kind,
   input  logic [ers_pkg::SLOT_IDX_W-1:0]    req_slot_index,
   input  logic [ers_pkg::CHUNK_W-1:0]       req_extent_first_chunk,
   input  logic [ers_pkg::EXT_LEN_W-1:0]     req_extent_length,
   input  logic                              req_extent_unused,
   input  logic [ers_pkg::OFFSET_W-1:0]      req_read_offset,
   input  logic [ers_pkg::LENGTH_W-1:0]      req_read_length,
   input  logic [ers_pkg::BUF_W-1:0]         req_buffer_bytes,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ers_pkg::CHUNK_W-1:0]       rsp_physical_chunk,
   output logic [ers_pkg::SEG_START_W-1:0]   rsp_segment_start,
   output logic [ers_pkg::SEG_BYTES_W-1:0]   rsp_segment_bytes,
   output logic [ers_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_last
);
   import ers_pkg::*;

   localparam int SLOT_W = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;
   localparam int RUN_W  = EXT_LEN_W + SLOT_W;
   localparam int CMP_W  = ((POS_W > RUN_W) ? POS_W : RUN_W) + 1;

   // Extent table
   logic [CHUNK_W-1:0]    base_ff [EXTENT_SLOTS];
   logic [EXT_LEN_W-1:0]  size_ff [EXTENT_SLOTS];
   logic [EXTENT_SLOTS-1:0] empty_ff;
   logic                  tbl_we;
   logic [SLOT_W-1:0]     wr_idx;

   logic [FCC_W-1:0]      fcc_ff;

   // Latched request
   logic [OFFSET_W-1:0]   off_ff;
   logic [LENGTH_W-1:0]   len_ff;
   logic [BUF_W-1:0]      buf_ff;

   // Piece and walk state
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CHUNK_LOG2-1:0] start_ff, start_in;
   logic [LENGTH_W-1:0]   rem_ff, rem_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [RUN_W-1:0]      run_ff, run_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHUNK_W-1:0]    phys_ff, phys_in;
   logic [CHUNK_LOG2-1:0] seg_start_ff, seg_start_in;
   logic [BYTES_W-1:0]    seg_bytes_ff, seg_bytes_in;
   status_type            status_ff, status_in;
   logic                  last_ff, last_in;

   logic [CHUNK_W-1:0]    cur_base;
   logic [EXT_LEN_W-1:0]  cur_size;
   logic                  cur_empty;
   logic [CMP_W-1:0]      pos_ext, run_ext, end_ext;
   logic                  pos_oob;
   logic [CHUNK_W-1:0]    phys_calc;
   logic                  walk_done, walk_err;
   status_type            walk_code;
   logic [BYTES_W-1:0]    room;
   logic                  piece_last;
   logic [BYTES_W-1:0]    piece_bytes;
   logic [CHK_W-1:0]      chk_sum, chk_limit;
   logic                  check_fail;
   status_type            check_code;
   logic                  out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fcc_ff <= '0;
      end else if (csr_valid) begin
         fcc_ff <= csr_wdata;
      end
   end

   assign tbl_we = cmd.take_req && (req_kind == 1'b0) && (32'(req_slot_index) < EXTENT_SLOTS);
   assign wr_idx = SLOT_W'(req_slot_index);

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         base_ff[wr_idx] <= req_extent_first_chunk;
         size_ff[wr_idx] <= req_extent_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= '1;
      end else if (tbl_we) begin
         empty_ff[wr_idx] <= req_extent_unused;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         off_ff <= req_read_offset;
         len_ff <= req_read_length;
         buf_ff <= req_buffer_bytes;
      end
   end

   // Request checks, in priority order
   assign chk_sum   = CHK_W'(off_ff) + CHK_W'(len_ff);
   assign chk_limit = CHK_W'({fcc_ff, {CHUNK_LOG2{1'b0}}});

   always_comb begin
      check_fail = 1'b1;
      check_code = STAT_OK;
      if (chk_sum > chk_limit) begin
         check_code = STAT_OOB;
      end else if (len_ff == '0) begin
         check_code = STAT_ZERO_LEN;
      end else if (buf_ff < BUF_W'(len_ff)) begin
         check_code = STAT_BUF_SMALL;
      end else if (32'(len_ff) > MAX_READ_BYTES) begin
         check_code = STAT_TOO_LONG;
      end else begin
         check_fail = 1'b0;
      end
   end

   // One extent slot per cycle
   assign cur_base  = base_ff[slot_ff];
   assign cur_size  = size_ff[slot_ff];
   assign cur_empty = empty_ff[slot_ff];
   assign pos_ext   = CMP_W'(pos_ff);
   assign run_ext   = CMP_W'(run_ff);
   assign end_ext   = run_ext + CMP_W'(cur_size);
   assign pos_oob   = POS_CMP_W'(pos_ff) >= POS_CMP_W'(fcc_ff);
   assign phys_calc = cur_base + CHUNK_W'(pos_ext - run_ext);

   always_comb begin
      walk_done = 1'b1;
      walk_err  = 1'b1;
      walk_code = STAT_OK;
      if (pos_oob) begin
         walk_code = STAT_OOB;
      end else if (cur_empty) begin
         walk_code = STAT_EXTENTS_END;
      end else if (pos_ext < end_ext) begin
         walk_err = 1'b0;
      end else if (slot_ff == SLOT_W'(EXTENT_SLOTS - 1)) begin
         walk_code = STAT_NOT_IN_FILE;
      end else begin
         walk_done = 1'b0;
         walk_err  = 1'b0;
      end
   end

   // Piece size: the rest of the current chunk, or what remains of the read
   assign room        = BYTES_W'(CHUNK_BYTES) - BYTES_W'(start_ff);
   assign piece_last  = rem_ff <= LENGTH_W'(room);
   assign piece_bytes = piece_last ? BYTES_W'(rem_ff) : room;

   always_comb begin
      pos_in   = pos_ff;
      start_in = start_ff;
      rem_in   = rem_ff;
      slot_in  = slot_ff;
      run_in   = run_ff;
      if (cmd.start_walk) begin
         pos_in   = POS_W'(off_ff >> CHUNK_LOG2);
         start_in = off_ff[CHUNK_LOG2-1:0];
         rem_in   = len_ff;
         slot_in  = '0;
         run_in   = '0;
      end else if (cmd.next_piece) begin
         pos_in   = pos_ff + POS_W'(1);
         start_in = '0;
         rem_in   = rem_ff - LENGTH_W'(piece_bytes);
         slot_in  = '0;
         run_in   = '0;
      end else if (cmd.step_slot) begin
         slot_in  = slot_ff + SLOT_W'(1);
         run_in   = run_ff + RUN_W'(cur_size);
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      start_ff <= start_in;
      rem_ff   <= rem_in;
      slot_ff  <= slot_in;
      run_ff   <= run_in;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      phys_in      = '0;
      seg_start_in = '0;
      seg_bytes_in = '0;
      status_in    = STAT_OK;
      last_in      = 1'b1;
      case (cmd.emit_kind)
         EMIT_ACK: begin
            status_in = STAT_OK;
         end
         EMIT_CHECK: begin
            status_in = check_code;
         end
         EMIT_WALK: begin
            if (walk_err) begin
               status_in = walk_code;
            end else begin
               phys_in      = phys_calc;
               seg_start_in = start_ff;
               seg_bytes_in = piece_bytes;
               last_in      = piece_last;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         phys_ff      <= phys_in;
         seg_start_ff <= seg_start_in;
         seg_bytes_ff <= seg_bytes_in;
         status_ff    <= status_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_physical_chunk = phys_ff;
   assign rsp_segment_start  = SEG_START_W'(seg_start_ff);
   assign rsp_segment_bytes  = SEG_BYTES_W'(seg_bytes_ff);
   assign rsp_status         = status_ff;
   assign rsp_last           = last_ff;

   assign stat.req_is_read = (req_kind == 1'b1);
   assign stat.check_fail  = check_fail;
   assign stat.walk_done   = walk_done;
   assign stat.walk_err    = walk_err;
   assign stat.piece_last  = piece_last;
   assign stat.out_free    = out_free;

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_step_unresolved: assert property (@(posedge clock) disable iff (reset)
      cmd.step_slot |-> !walk_done)
      else $error("walk advanced past a resolved slot");

   a_piece_restarts_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.next_piece |=> (slot_ff == '0 && run_ff == '0))
      else $error("next piece did not restart the extent walk");

   a_bytes_remain: assert property (@(posedge clock) disable iff (reset)
      (cmd.next_piece && !piece_last) |=> (rem_ff != '0))
      else $error("read ran out of bytes before its last piece");

endmodule

// ===== hdl/extent_read_splitter_unit.sv =====
// Extent read splitter.
// Request channel (req_*): kind 0 writes one extent slot, kind 1 is a read
// of read_length bytes at read_offset into a buffer of buffer_bytes.
// Result channel (rsp_*): one result per extent write; for a read, either
// one error result or one segment per chunk touched, the final one flagged
// by rsp_last. A walk error ends the read with one more error result.
// Config channel (csr_*): file_chunk_count, always ready; the user must see
// that it is written while idle, as the block does not enforce this. An
// extent write is taken in idle, and its result is loaded into the output
// register from the ack state. A read is latched on acceptance, checked in
// the check state, and then each segment walks the extent table from slot
// 0 one slot per cycle. A full-length read touches up to 33 segments.
// A new request is taken once the previous one has produced its last result
// into the output register, even while that result still waits to be taken.
// If the receiver stalls, the walk holds on its resolved segment.
// Reset empties every extent slot and clears file_chunk_count to 0.
module extent_read_splitter_unit #(
   parameter int EXTENT_SLOTS = ers_pkg::DEFAULT_EXTENT_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ers_pkg::FCC_W-1:0]         csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ers_pkg::KIND_W-1:0]        req_kind,
   input  logic [ers_pkg::SLOT_IDX_W-1:0]    req_slot_index,
   input  logic [ers_pkg::CHUNK_W-1:0]       req_extent_first_chunk,
   input  logic [ers_pkg::EXT_LEN_W-1:0]     req_extent_length,
   input  logic                              req_extent_unused,
   input  logic [ers_pkg::OFFSET_W-1:0]      req_read_offset,
   input  logic [ers_pkg::LENGTH_W-1:0]      req_read_length,
   input  logic [ers_pkg::BUF_W-1:0]         req_buffer_bytes,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ers_pkg::CHUNK_W-1:0]       rsp_physical_chunk,
   output logic [ers_pkg::SEG_START_W-1:0]   rsp_segment_start,
   output logic [ers_pkg::SEG_BYTES_W-1:0]   rsp_segment_bytes,
   output logic [ers_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_last
);
   import ers_pkg::*;

   ers_cmd_type    cmd;
   ers_status_type stat;

   ers_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ers_datapath #(
      .EXTENT_SLOTS (EXTENT_SLOTS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_wdata              (csr_wdata),
      .req_kind               (req_kind),
      .req_slot_index         (req_slot_index),
      .req_extent_first_chunk (req_extent_first_chunk),
      .req_extent_length      (req_extent_length),
      .req_extent_unused      (req_extent_unused),
      .req_read_offset        (req_read_offset),
      .req_read_length        (req_read_length),
      .req_buffer_bytes       (req_buffer_bytes),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_physical_chunk     (rsp_physical_chunk),
      .rsp_segment_start      (rsp_segment_start),
      .rsp_segment_bytes      (rsp_segment_bytes),
      .rsp_status             (rsp_status),
      .rsp_last               (rsp_last)
   );

endmodule

// ===== tb/tb_extent_read_splitter_unit.sv =====
`timescale 1ns / 1ps

module tb_extent_read_splitter_unit;
   import ers_pkg::*;

   localparam bit KIND_EXTENT_WRITE = 1'b0;
   localparam bit KIND_READ         = 1'b1;
   localparam int TABLE_SLOTS       = DEFAULT_EXTENT_SLOTS;
   localparam int MAX_OFFSET        = (1 << OFFSET_W) - 1;
   localparam int HOLD_CYCLES       = 400;
   localparam int DRAIN_CYCLES      = 300;
   localparam int CYCLE_LIMIT       = 600000;
   localparam int MAX_REPORTS       = 10;

   typedef struct {
      logic [KIND_W-1:0]     kind;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [CHUNK_W-1:0]    first_chunk;
      logic [EXT_LEN_W-1:0]  extent_length;
      logic                  extent_unused;
      logic [OFFSET_W-1:0]   read_offset;
      logic [LENGTH_W-1:0]   read_length;
      logic [BUF_W-1:0]      buffer_bytes;
   } request_t;

   typedef struct {
      logic [CHUNK_W-1:0]     chunk;
      logic [SEG_START_W-1:0] start;
      logic [SEG_BYTES_W-1:0] bytes;
      status_type             status;
      logic                   last;
   } segment_t;

   typedef struct {
      bit                 is_csr;
      logic [FCC_W-1:0]   csr_value;
      request_t           req;
      bit                 has_fixed;
      segment_t           fixed;
   } stim_row_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [FCC_W-1:0]       csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind;
   logic [SLOT_IDX_W-1:0]  req_slot_index;
   logic [CHUNK_W-1:0]     req_extent_first_chunk;
   logic [EXT_LEN_W-1:0]   req_extent_length;
   logic                   req_extent_unused;
   logic [OFFSET_W-1:0]    req_read_offset;
   logic [LENGTH_W-1:0]    req_read_length;
   logic [BUF_W-1:0]       req_buffer_bytes;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CHUNK_W-1:0]     rsp_physical_chunk;
   logic [SEG_START_W-1:0] rsp_segment_start;
   logic [SEG_BYTES_W-1:0] rsp_segment_bytes;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_last;

   // shadow of the extent table and the chunk count register
   logic [CHUNK_W-1:0]   ext_base  [TABLE_SLOTS] = '{default: '0};
   logic [EXT_LEN_W-1:0] ext_size  [TABLE_SLOTS] = '{default: '0};
   bit                   ext_empty [TABLE_SLOTS] = '{default: 1'b1};
   logic [FCC_W-1:0]     chunk_count = '0;

   segment_t  planned_segments[$];
   segment_t  pending_segments[$];
   stim_row_t directed_rows[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  idle_pct       = 0;
   bit  hold_request   = 0;

   extent_read_splitter_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_kind               (req_kind),
      .req_slot_index         (req_slot_index),
      .req_extent_first_chunk (req_extent_first_chunk),
      .req_extent_length      (req_extent_length),
      .req_extent_unused      (req_extent_unused),
      .req_read_offset        (req_read_offset),
      .req_read_length        (req_read_length),
      .req_buffer_bytes       (req_buffer_bytes),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_physical_chunk     (rsp_physical_chunk),
      .rsp_segment_start      (rsp_segment_start),
      .rsp_segment_bytes      (rsp_segment_bytes),
      .rsp_status             (rsp_status),
      .rsp_last               (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic segment_t make_segment(input logic [CHUNK_W-1:0] chunk,
                                             input int start, input int bytes,
                                             input status_type status,
                                             input logic last);
      segment_t s;
      s.chunk  = chunk;
      s.start  = SEG_START_W'(start);
      s.bytes  = SEG_BYTES_W'(bytes);
      s.status = status;
      s.last   = last;
      return s;
   endfunction

   // translate a logical chunk by walking the extents from slot 0
   function automatic status_type map_chunk(input longint unsigned pos,
                                            output logic [CHUNK_W-1:0] phys);
      longint unsigned run;
      int i;
      run  = 0;
      phys = '0;
      if (pos >= longint'(chunk_count)) return STAT_OOB;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (ext_empty[i]) return STAT_EXTENTS_END;
         if (pos < run + ext_size[i]) begin
            phys = CHUNK_W'(ext_base[i] + (pos - run));
            return STAT_OK;
         end
         run += ext_size[i];
      end
      return STAT_NOT_IN_FILE;
   endfunction

   // update the shadow table, or split a read into its segment commands
   function automatic void plan_segments(input request_t r);
      longint unsigned off, amt, bsz, first_off, first_idx, first_size;
      longint unsigned rest, full_cnt, final_size, j;
      logic [CHUNK_W-1:0] phys;
      status_type st;
      planned_segments = {};
      if (r.kind == KIND_EXTENT_WRITE) begin
         ext_base[r.slot_index]  = r.first_chunk;
         ext_size[r.slot_index]  = r.extent_length;
         ext_empty[r.slot_index] = r.extent_unused;
         planned_segments.push_back(make_segment('0, 0, 0, STAT_OK, 1'b1));
         return;
      end
      off = r.read_offset;
      amt = r.read_length;
      bsz = r.buffer_bytes;
      if (off + amt > longint'(chunk_count) * CHUNK_BYTES) begin
         planned_segments.push_back(make_segment('0, 0, 0, STAT_OOB, 1'b1));
         return;
      end
      if (amt == 0) begin
         planned_segments.push_back(make_segment('0, 0, 0, STAT_ZERO_LEN, 1'b1));
         return;
      end
      if (bsz < amt) begin
         planned_segments.push_back(make_segment('0, 0, 0, STAT_BUF_SMALL, 1'b1));
         return;
      end
      if (amt > MAX_READ_BYTES) begin
         planned_segments.push_back(make_segment('0, 0, 0, STAT_TOO_LONG, 1'b1));
         return;
      end
      first_off  = off % CHUNK_BYTES;
      first_idx  = off / CHUNK_BYTES;
      first_size = CHUNK_BYTES - first_off;
      st = map_chunk(first_idx, phys);
      if (st != STAT_OK) begin
         planned_segments.push_back(make_segment('0, 0, 0, st, 1'b1));
         return;
      end
      if (amt <= first_size) begin
         planned_segments.push_back(make_segment(phys, first_off, amt, STAT_OK, 1'b1));
         return;
      end
      rest       = amt - first_size;
      full_cnt   = rest / CHUNK_BYTES;
      final_size = rest % CHUNK_BYTES;
      planned_segments.push_back(make_segment(phys, first_off, first_size, STAT_OK,
                                              full_cnt == 0 && final_size == 0));
      for (j = 0; j < full_cnt; j++) begin
         st = map_chunk(first_idx + 1 + j, phys);
         if (st != STAT_OK) begin
            planned_segments.push_back(make_segment('0, 0, 0, st, 1'b1));
            return;
         end
         planned_segments.push_back(make_segment(phys, 0, CHUNK_BYTES, STAT_OK,
                                                 j + 1 == full_cnt && final_size == 0));
      end
      if (final_size != 0) begin
         st = map_chunk(first_idx + full_cnt + 1, phys);
         if (st != STAT_OK) begin
            planned_segments.push_back(make_segment('0, 0, 0, st, 1'b1));
            return;
         end
         planned_segments.push_back(make_segment(phys, 0, final_size, STAT_OK, 1'b1));
      end
   endfunction

   function automatic request_t random_request();
      request_t r;
      r.kind          = KIND_W'($urandom);
      r.slot_index    = SLOT_IDX_W'($urandom);
      r.first_chunk   = CHUNK_W'($urandom);
      r.extent_length = EXT_LEN_W'($urandom);
      r.extent_unused = 1'($urandom);
      r.read_offset   = OFFSET_W'($urandom);
      r.read_length   = LENGTH_W'($urandom);
      r.buffer_bytes  = BUF_W'($urandom);
      return r;
   endfunction

   // mostly well-formed reads inside the file, the rest rejects and noise
   function automatic request_t make_read();
      request_t r;
      int unsigned mode, len, file_bytes, max_off;
      r = random_request();
      r.kind = KIND_READ;
      file_bytes = chunk_count * CHUNK_BYTES;
      mode = $urandom_range(0, 99);
      if (mode < 80 && file_bytes != 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 1024);
            6, 7, 8:          len = $urandom_range(1, 4096);
            default:          len = $urandom_range(1, MAX_READ_BYTES);
         endcase
         if (len > file_bytes) len = file_bytes;
         max_off = file_bytes - len;
         if (max_off > MAX_OFFSET) max_off = MAX_OFFSET;
         r.read_offset = OFFSET_W'($urandom_range(0, max_off));
         r.read_length = LENGTH_W'(len);
         if (mode < 72) r.buffer_bytes = BUF_W'($urandom_range(len, 65535));
         else r.buffer_bytes = BUF_W'($urandom_range(0, len - 1));
      end else if (mode < 88) begin
         len = $urandom_range(MAX_READ_BYTES + 1, (1 << LENGTH_W) - 1);
         r.read_offset  = OFFSET_W'($urandom_range(0, 1023));
         r.read_length  = LENGTH_W'(len);
         r.buffer_bytes = BUF_W'($urandom_range(len, 65535));
      end else if (mode < 92) begin
         r.read_length = '0;
      end
      return r;
   endfunction

   task automatic apply_accepted(input request_t r, input bit has_fixed,
                                 input segment_t fixed);
      plan_segments(r);
      if (has_fixed) pending_segments.push_back(fixed);
      else foreach (planned_segments[i]) pending_segments.push_back(planned_segments[i]);
   endtask

   task automatic send_request(input request_t r, input bit has_fixed,
                               input segment_t fixed);
      int gap;
      @(negedge clock);
      req_kind               = r.kind;
      req_slot_index         = r.slot_index;
      req_extent_first_chunk = r.first_chunk;
      req_extent_length      = r.extent_length;
      req_extent_unused      = r.extent_unused;
      req_read_offset        = r.read_offset;
      req_read_length        = r.read_length;
      req_buffer_bytes       = r.buffer_bytes;
      req_valid              = 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_accepted(r, has_fixed, fixed);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold the sender until every expected segment has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [FCC_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      chunk_count = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // fill all slots; used extents cover the file unless short_cover is set
   task automatic load_extent_map(input bit short_cover);
      request_t r;
      int unsigned remaining, len;
      int s, n_used;
      segment_t none;
      none = make_segment('0, 0, 0, STAT_OK, 1'b0);
      remaining = chunk_count;
      n_used = $urandom_range(1, TABLE_SLOTS);
      for (s = 0; s < TABLE_SLOTS; s++) begin
         r = random_request();
         r.kind = KIND_EXTENT_WRITE;
         r.slot_index = SLOT_IDX_W'(s);
         if (s < n_used - 1) begin
            len = $urandom_range(0, remaining / 2 + 1);
            if (len > remaining) len = remaining;
            r.extent_length = EXT_LEN_W'(len);
            r.extent_unused = 1'b0;
            remaining -= len;
         end else if (s == n_used - 1) begin
            r.extent_length = EXT_LEN_W'(short_cover ? remaining / 2 : remaining);
            r.extent_unused = 1'b0;
         end else begin
            r.extent_unused = 1'b1;
         end
         send_request(r, 1'b0, none);
      end
   endtask

   task automatic add_csr_row(input logic [FCC_W-1:0] value);
      stim_row_t row;
      row = '{default: '0};
      row.is_csr    = 1'b1;
      row.csr_value = value;
      directed_rows.push_back(row);
   endtask

   task automatic add_write_row(input int slot, input int first, input int len,
                                input bit unused);
      stim_row_t row;
      row = '{default: '0};
      row.req.kind          = KIND_EXTENT_WRITE;
      row.req.slot_index    = SLOT_IDX_W'(slot);
      row.req.first_chunk   = CHUNK_W'(first);
      row.req.extent_length = EXT_LEN_W'(len);
      row.req.extent_unused = unused;
      row.has_fixed = 1'b1;
      row.fixed     = make_segment('0, 0, 0, STAT_OK, 1'b1);
      directed_rows.push_back(row);
   endtask

   task automatic add_read_row(input int off, input int len, input int bsz,
                               input bit has_fixed, input status_type status);
      stim_row_t row;
      row = '{default: '0};
      row.req.kind         = KIND_READ;
      row.req.read_offset  = OFFSET_W'(off);
      row.req.read_length  = LENGTH_W'(len);
      row.req.buffer_bytes = BUF_W'(bsz);
      row.has_fixed = has_fixed;
      row.fixed     = make_segment('0, 0, 0, status, 1'b1);
      directed_rows.push_back(row);
   endtask

   function automatic logic [FCC_W-1:0] phase_chunk_count(input int phase);
      case (phase)
         0:       return FCC_W'(65536);
         1:       return FCC_W'($urandom_range(1, 64));
         2:       return '0;
         3:       return FCC_W'($urandom);
         4:       return FCC_W'($urandom_range(1, 2048));
         5:       return FCC_W'(65536);
         default: return FCC_W'($urandom_range(1, 64));
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      segment_t exp_seg;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_segments.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: chunk=%0d start=%0d bytes=%0d status=%0d last=%0d",
                        rsp_physical_chunk, rsp_segment_start, rsp_segment_bytes,
                        rsp_status, rsp_last);
         end else begin
            exp_seg = pending_segments.pop_front();
            if (rsp_physical_chunk !== exp_seg.chunk || rsp_segment_start !== exp_seg.start ||
                rsp_segment_bytes !== exp_seg.bytes || rsp_status !== exp_seg.status ||
                rsp_last !== exp_seg.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected chunk=%0d start=%0d bytes=%0d status=%0d last=%0d, got chunk=%0d start=%0d bytes=%0d status=%0d last=%0d",
                           exp_seg.chunk, exp_seg.start, exp_seg.bytes, exp_seg.status,
                           exp_seg.last, rsp_physical_chunk, rsp_segment_start,
                           rsp_segment_bytes, rsp_status, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int cnt;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            for (cnt = 0; cnt < HOLD_CYCLES; cnt++) @(negedge clock);
            hold_request = 1'b0;
            rsp_ready = 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin
      int phase, n, n_reads;
      request_t r;
      segment_t none;
      none = make_segment('0, 0, 0, STAT_OK, 1'b0);
      reset                  = 1'b1;
      csr_valid              = 1'b0;
      csr_wdata              = '0;
      req_valid              = 1'b0;
      req_kind               = '0;
      req_slot_index         = '0;
      req_extent_first_chunk = '0;
      req_extent_length      = '0;
      req_extent_unused      = 1'b0;
      req_read_offset        = '0;
      req_read_length        = '0;
      req_buffer_bytes       = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty file after reset
      add_read_row(0, 0, 0, 1'b1, STAT_ZERO_LEN);
      add_read_row(0, 1, 1, 1'b1, STAT_OOB);
      add_csr_row(16);
      add_read_row(0, 512, 512, 1'b0, STAT_OK);
      // 16 chunks over three extents, the second one wrapping past 0xffff
      add_write_row(0, 100, 4, 1'b0);
      add_write_row(1, 16'hFFFE, 4, 1'b0);
      add_write_row(2, 500, 8, 1'b0);
      add_write_row(3, 16'h1234, 3, 1'b1);
      add_read_row(0, 512, 1000, 1'b0, STAT_OK);
      add_read_row(300, 3000, 4000, 1'b0, STAT_OK);
      add_read_row(0, 8192, 8192, 1'b0, STAT_OK);
      add_read_row(8000, 192, 192, 1'b0, STAT_OK);
      add_read_row(8000, 193, 193, 1'b1, STAT_OOB);
      add_read_row(10, 20, 19, 1'b1, STAT_BUF_SMALL);
      add_csr_row(65536);
      add_read_row(0, 16385, 65535, 1'b1, STAT_TOO_LONG);
      // walk runs into the empty slot after one segment
      add_read_row(8000, 1000, 1000, 1'b0, STAT_OK);
      // fill every slot so the walk can fall off the end of the table
      add_write_row(3, 7, 8, 1'b0);
      add_write_row(4, 16'hFFFF, 1, 1'b0);
      add_write_row(5, 0, 1, 1'b0);
      add_write_row(6, 0, 1, 1'b0);
      add_write_row(7, 0, 1, 1'b0);
      add_read_row(28 * 512, 16384, 65535, 1'b0, STAT_OK);
      add_read_row(24 * 512 - 10, 20, 20, 1'b0, STAT_OK);
      add_write_row(7, 16'hFFFF, 65536, 1'b0);
      add_read_row(MAX_OFFSET, 1, 1, 1'b0, STAT_OK);
      add_csr_row(0);
      add_read_row(0, 1, 1, 1'b1, STAT_OOB);

      idle_pct = 20;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_idle();
            write_csr(directed_rows[i].csr_value);
         end else begin
            send_request(directed_rows[i].req, directed_rows[i].has_fixed,
                         directed_rows[i].fixed);
         end
      end

      for (phase = 0; phase < 7; phase++) begin
         wait_idle();
         case (phase)
            0: idle_pct = 25;
            1: idle_pct = 50;
            2: idle_pct = 0;
            3: idle_pct = 25;
            4: idle_pct = 10;
            5: idle_pct = 40;
            default: idle_pct = 0;
         endcase
         write_csr(phase_chunk_count(phase));
         load_extent_map(phase == 5);
         // let the receiver stall long enough to back up the request side
         if (phase == 1) hold_request = 1'b1;
         n_reads = (phase == 2) ? 8 : 14;
         for (n = 0; n < n_reads; n++) begin
            if ($urandom_range(0, 19) == 0) begin
               r = random_request();
               r.kind = KIND_EXTENT_WRITE;
            end else begin
               r = make_read();
            end
            send_request(r, 1'b0, none);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_segments.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
